// ----- src/kvma_pkg.sv -----
// ----------------------------------------------------------------------------
// kvma_pkg
// Shared types and constants of the multiplicity assignment block: register
// indexes and reset values, fixed widths, and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package kvma_pkg;

	// configuration register indexes
	localparam logic CFG_Z_WEIGHT = 1'b0;
	localparam logic CFG_MAX_Z    = 1'b1;

	// configuration reset values
	localparam logic [9:0] Z_WEIGHT_RST = 10'd54;
	localparam logic [2:0] MAX_Z_RST    = 3'd5;

	// fixed widths
	localparam int DEG_W   = 14;  // weighted degree, up to 8 * 1023
	localparam int CNT_W   = 20;  // monomial count
	localparam int DVS_W   = 5;   // divisor, up to 17
	localparam int REL_X_W = 24;  // widest reliability

	localparam logic [3:0] MULT_MAX = 4'd15;

	// controller to datapath
	typedef struct packed {
		logic load;      // write the input item into the reliability store
		logic run_init;  // clear run state
		logic cnt_clr;   // zero position and symbol counters
		logic cnt_step;  // advance over the matrix, symbol inner
		logic col_step;  // advance symbol counter only
		logic pos_step;  // advance position counter only
		logic clr_wr;    // zero one multiplicity
		logic scan_rd;   // read one reliability for the argmax
		logic best_clr;  // restart the argmax
		logic m_rd;      // read multiplicity of the best entry
		logic div_rel;   // start reliability division
		logic upd;       // write back the greedy step
		logic cnt_init;  // start a monomial count
		logic cnt_next_c;
		logic cnt_div;   // capture one count term quotient
		logic cnt_acc;   // accumulate one count term
		logic d_inc;     // try the next degree
		logic col_clr;
		logic col_rd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic s_last;
		logic p_last;
		logic best_zero;
		logic div_busy;
		logic c_done;
		logic a_done;
		logic n_gt_idx;
		logic d_ge_lim;
	} stat_t;

	typedef enum logic [19:0] {
		ST_IDLE      = 20'h00001,
		ST_CLR       = 20'h00002,
		ST_SCAN_INIT = 20'h00004,
		ST_SCAN      = 20'h00008,
		ST_SCAN_END  = 20'h00010,
		ST_DECIDE    = 20'h00020,
		ST_MREAD     = 20'h00040,
		ST_DIV_START = 20'h00080,
		ST_DIV_WAIT  = 20'h00100,
		ST_UPDATE    = 20'h00200,
		ST_DEG_CHECK = 20'h00400,
		ST_CNT_INIT  = 20'h00800,
		ST_CNT_TERM  = 20'h01000,
		ST_CNT_WAIT  = 20'h02000,
		ST_CNT_DONE  = 20'h04000,
		ST_OUT_INIT  = 20'h08000,
		ST_COL_INIT  = 20'h10000,
		ST_COL_READ  = 20'h20000,
		ST_COL_END   = 20'h40000,
		ST_OUT       = 20'h80000
	} state_t;

endpackage

`default_nettype wire

// ----- src/kvma_in_if.sv -----
// ----------------------------------------------------------------------------
// kvma_in_if
// Reliability entry channel: valid/ready with one matrix entry per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvma_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  symbol_index;
	logic [5:0]  position;
	logic [15:0] reliability;
	logic        last_entry;

	modport source (output valid, symbol_index, position, reliability, last_entry,
		input ready);
	modport sink (input valid, symbol_index, position, reliability, last_entry,
		output ready);
endinterface

`default_nettype wire

// ----- src/kvma_out_if.sv -----
// ----------------------------------------------------------------------------
// kvma_out_if
// Multiplicity column channel: valid/ready with one column per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvma_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_position;
	logic [63:0] column_multiplicities;
	logic [15:0] total_cost;
	logic [3:0]  max_multiplicity;
	logic        overflow;
	logic        last_column;

	modport source (output valid, out_position, column_multiplicities, total_cost,
		max_multiplicity, overflow, last_column, input ready);
	modport sink (input valid, out_position, column_multiplicities, total_cost,
		max_multiplicity, overflow, last_column, output ready);
endinterface

`default_nettype wire

// ----- src/kvma_cfg_if.sv -----
// ----------------------------------------------------------------------------
// kvma_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvma_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/kv_multiplicity_assignment.sv -----
// ----------------------------------------------------------------------------
// kv_multiplicity_assignment
// Greedy multiplicity assignment over a symbols-by-positions reliability
// matrix, emitting one packed multiplicity column per position.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      item
//   load     in   valid/ready    one reliability entry, last_entry starts a run
//   result   out  valid/ready    one multiplicity column per position
//   cfg      in   valid/ready    register index and write data, always ready
//
// Entries load at one per cycle while the block is idle. A run starts with a
// clearing pass over the whole multiplicity store. Each greedy step costs a
// full argmax scan, one serial division and a degree walk that counts
// monomials one term at a time for each degree tried. Each column is then
// read from the multiplicity store and held on result until it is taken.
// Reset is asynchronous; the reliability store holds no reset value.
//
`default_nettype none

module kv_multiplicity_assignment #(
	parameter int NUM_SYMBOLS      = 16,
	parameter int NUM_POSITIONS    = 64,
	parameter int X_WEIGHT         = 4,
	parameter int RELIABILITY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	kvma_in_if.sink     load,
	kvma_out_if.source  result,
	kvma_cfg_if.sink    cfg
);
	import kvma_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	kvma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (load.valid),
		.in_last   (load.last_entry),
		.in_ready  (load.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kvma_dp #(
		.NUM_SYMBOLS      (NUM_SYMBOLS),
		.NUM_POSITIONS    (NUM_POSITIONS),
		.X_WEIGHT         (X_WEIGHT),
		.RELIABILITY_BITS (RELIABILITY_BITS)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.stat                  (stat),
		.symbol_index          (load.symbol_index),
		.position              (load.position),
		.reliability           (load.reliability),
		.cfg_wr                (cfg.valid),
		.cfg_index             (cfg.index),
		.cfg_data              (cfg.data),
		.out_position          (result.out_position),
		.column_multiplicities (result.column_multiplicities),
		.total_cost            (result.total_cost),
		.max_multiplicity      (result.max_multiplicity),
		.overflow              (result.overflow),
		.last_column           (result.last_column)
	);

endmodule

`default_nettype wire

// ----- src/kvma_ram.sv -----
// ----------------------------------------------------------------------------
// kvma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kvma_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/kvma_div.sv -----
// ----------------------------------------------------------------------------
// kvma_div
// Restoring divider by a small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kvma_div #(
	parameter int DW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              dividend,
	input  logic [kvma_pkg::DVS_W-1:0] divisor,
	output logic                       busy,
	output logic [DW-1:0]              quotient
);
	import kvma_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DW-1:0]    quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fit;

	// one trial subtraction per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fit};
			rem_q <= fit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- src/kvma_dp.sv -----
// ----------------------------------------------------------------------------
// kvma_dp
// Datapath: reliability and multiplicity stores, argmax scan, reliability
// divider, cost and degree tracking, monomial counting and column assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module kvma_dp #(
	parameter int NUM_SYMBOLS      = 16,
	parameter int NUM_POSITIONS    = 64,
	parameter int X_WEIGHT         = 4,
	parameter int RELIABILITY_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kvma_pkg::cmd_t      cmd,
	output kvma_pkg::stat_t     stat,
	input  logic [3:0]          symbol_index,
	input  logic [5:0]          position,
	input  logic [15:0]         reliability,
	input  logic                cfg_wr,
	input  logic                cfg_index,
	input  logic [9:0]          cfg_data,
	output logic [5:0]          out_position,
	output logic [63:0]         column_multiplicities,
	output logic [15:0]         total_cost,
	output logic [3:0]          max_multiplicity,
	output logic                overflow,
	output logic                last_column
);
	import kvma_pkg::*;

	localparam int SW    = $clog2(NUM_SYMBOLS);
	localparam int PW    = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
	localparam int AW    = SW + PW;
	localparam int DEPTH = 1 << AW;
	localparam int RB    = RELIABILITY_BITS;
	localparam int DW    = RB;
	localparam logic [SW-1:0] S_MAX = SW'(NUM_SYMBOLS - 1);
	localparam logic [PW-1:0] P_MAX = PW'(NUM_POSITIONS - 1);
	// reciprocal of x weight plus one, exact for every term below 2^DEG_W
	localparam int QS = DEG_W + DVS_W;
	localparam int PRW = DEG_W + QS;
	localparam logic [QS-1:0] QR = QS'(((1 << QS) + X_WEIGHT) / (X_WEIGHT + 1));

	logic [9:0]       zw_q;
	logic [2:0]       lz_q;
	logic [9:0]       zw_eff;
	logic [PW-1:0]    p_q;
	logic [SW-1:0]    s_q;
	logic [AW-1:0]    cur_addr;
	logic [AW-1:0]    in_addr;
	logic             in_rng;
	logic [REL_X_W-1:0] rel_x;
	logic [RB-1:0]    rel_rdata;
	logic [3:0]       m_rdata;
	logic             sv_s1;
	logic [AW-1:0]    sa_s1;
	logic [RB-1:0]    best_q;
	logic [AW-1:0]    ba_q;
	logic [3:0]       m_q;
	logic [3:0]       m_inc;
	logic [16:0]      cost_sum;
	logic [15:0]      cost_q;
	logic [3:0]       max_q;
	logic             ovf_q;
	logic [DEG_W-1:0] d_q;
	logic [DEG_W-1:0] lim_q;
	logic [3:0]       c_q;
	logic [DEG_W-1:0] cz_q;
	logic [4:0]       a_q;
	logic [8:0]       aw_q;
	logic [CNT_W-1:0] n_q;
	logic [DEG_W-1:0] dmc;
	logic [DEG_W-1:0] term_t;
	logic [PRW-1:0]   qprod;
	logic [DEG_W-1:0] cq_q;
	logic             div_start;
	logic [DW-1:0]    div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_busy;
	logic [DW-1:0]    div_q;
	logic             cv_s1;
	logic [SW-1:0]    cs_s1;
	logic [63:0]      col_q;
	logic             rel_we;
	logic [AW-1:0]    rel_waddr;
	logic [RB-1:0]    rel_wdata;
	logic             m_we;
	logic [AW-1:0]    m_waddr;
	logic [3:0]       m_wdata;
	logic [AW-1:0]    m_raddr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zw_q <= Z_WEIGHT_RST;
			lz_q <= MAX_Z_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_Z_WEIGHT: zw_q <= cfg_data;
				CFG_MAX_Z:    lz_q <= cfg_data[2:0];
				default:      ;
			endcase
		end
	end

	assign zw_eff = (zw_q == 10'd0) ? 10'd1 : zw_q;

	// input entry address and masking
	assign in_rng   = ({1'b0, symbol_index} < 5'(NUM_SYMBOLS))
		&& ({1'b0, position} < 7'(NUM_POSITIONS));
	assign in_addr  = {position[PW-1:0], symbol_index[SW-1:0]};
	assign rel_x    = REL_X_W'(reliability);
	assign cur_addr = {p_q, s_q};

	// position and symbol counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			s_q <= '0;
		end else if (cmd.cnt_clr) begin
			p_q <= '0;
			s_q <= '0;
		end else if (cmd.cnt_step) begin
			if (s_q == S_MAX) begin
				s_q <= '0;
				p_q <= (p_q == P_MAX) ? '0 : p_q + 1'b1;
			end else begin
				s_q <= s_q + 1'b1;
			end
		end else if (cmd.col_step) begin
			s_q <= (s_q == S_MAX) ? '0 : s_q + 1'b1;
		end else if (cmd.pos_step) begin
			p_q <= p_q + 1'b1;
		end
	end

	// reliability store
	assign rel_we    = (cmd.load && in_rng) || cmd.upd;
	assign rel_waddr = cmd.upd ? ba_q : in_addr;
	assign rel_wdata = cmd.upd ? div_q[RB-1:0] : rel_x[RB-1:0];

	kvma_ram #(.W(RB), .DEPTH(DEPTH)) u_rel_ram (
		.clk   (clk),
		.we    (rel_we),
		.waddr (rel_waddr),
		.wdata (rel_wdata),
		.raddr (cur_addr),
		.rdata (rel_rdata)
	);

	// multiplicity store
	assign m_inc   = m_q + 4'd1;
	assign m_we    = cmd.clr_wr || (cmd.upd && (m_q != MULT_MAX));
	assign m_waddr = cmd.upd ? ba_q : cur_addr;
	assign m_wdata = cmd.upd ? m_inc : 4'd0;
	assign m_raddr = cmd.m_rd ? ba_q : cur_addr;

	kvma_ram #(.W(4), .DEPTH(DEPTH)) u_mult_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	// argmax scan, first entry wins a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
			cv_s1 <= 1'b0;
		end else begin
			sv_s1 <= cmd.scan_rd;
			cv_s1 <= cmd.col_rd;
		end
	end

	always_ff @(posedge clk) begin
		sa_s1 <= cur_addr;
		cs_s1 <= s_q;
		if (cmd.best_clr) begin
			best_q <= '0;
			ba_q   <= '0;
		end else if (sv_s1 && (rel_rdata > best_q)) begin
			best_q <= rel_rdata;
			ba_q   <= sa_s1;
		end
	end

	// reliability divider by m+2
	assign div_start = cmd.div_rel;
	assign div_dvd   = best_q;
	assign div_dvs   = DVS_W'(m_rdata) + DVS_W'(2);

	kvma_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// run state: cost, largest multiplicity, overflow, degree
	assign cost_sum = 17'(cost_q) + 17'(m_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
			max_q  <= '0;
			ovf_q  <= 1'b0;
			d_q    <= '0;
			lim_q  <= '0;
		end else if (cmd.run_init) begin
			cost_q <= '0;
			max_q  <= '0;
			ovf_q  <= 1'b0;
			d_q    <= '0;
			lim_q  <= DEG_W'(DEG_W'(4'({1'b0, lz_q}) + 4'd1) * DEG_W'(zw_eff));
		end else if (cmd.upd) begin
			if (m_q == MULT_MAX) begin
				ovf_q <= 1'b1;
			end else begin
				if (cost_sum > 17'd65535) begin
					cost_q <= 16'hFFFF;
					ovf_q  <= 1'b1;
				end else begin
					cost_q <= cost_sum[15:0];
				end
				if (m_inc > max_q) begin
					max_q <= m_inc;
				end
			end
		end else if (cmd.d_inc) begin
			d_q <= d_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_rel) begin
			m_q <= m_rdata;
		end
	end

	// monomial count up to degree d, one (c, a) term at a time
	assign dmc    = d_q - cz_q;
	assign term_t = dmc - DEG_W'(aw_q);
	assign qprod  = PRW'(term_t) * PRW'(QR);

	// term quotient by x weight plus one, registered
	always_ff @(posedge clk) begin
		if (cmd.cnt_div) begin
			cq_q <= qprod[QS +: DEG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_init) begin
			c_q  <= '0;
			cz_q <= '0;
			a_q  <= '0;
			aw_q <= '0;
			n_q  <= '0;
		end else if (cmd.cnt_next_c) begin
			c_q  <= c_q + 1'b1;
			cz_q <= cz_q + DEG_W'(zw_eff);
			a_q  <= '0;
			aw_q <= '0;
		end else if (cmd.cnt_acc) begin
			n_q  <= n_q + CNT_W'(cq_q) + CNT_W'(1);
			a_q  <= a_q + 1'b1;
			aw_q <= aw_q + 9'(X_WEIGHT);
		end
	end

	// column assembly, unused nibbles stay zero
	always_ff @(posedge clk) begin
		if (cmd.col_clr) begin
			col_q <= '0;
		end else if (cv_s1) begin
			col_q[{cs_s1, 2'b00} +: 4] <= m_rdata;
		end
	end

	// status
	always_comb begin
		stat.s_last    = (s_q == S_MAX);
		stat.p_last    = (p_q == P_MAX);
		stat.best_zero = (best_q == '0);
		stat.div_busy  = div_busy;
		stat.c_done    = (c_q > {1'b0, lz_q}) || (cz_q > d_q);
		stat.a_done    = (a_q > 5'(X_WEIGHT)) || (DEG_W'(aw_q) > dmc);
		stat.n_gt_idx  = n_q > CNT_W'(cost_q);
		stat.d_ge_lim  = d_q >= lim_q;
	end

	// result payload
	assign out_position          = 6'(p_q);
	assign column_multiplicities = col_q;
	assign total_cost            = cost_q;
	assign max_multiplicity      = max_q;
	assign overflow              = ovf_q;
	assign last_column           = (p_q == P_MAX);

endmodule

`default_nettype wire

// ----- src/kvma_ctrl.sv -----
// ----------------------------------------------------------------------------
// kvma_ctrl
// Controller: sequences load, clearing pass, greedy steps, degree walk and
// column output.
// ----------------------------------------------------------------------------
`default_nettype none

module kvma_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  kvma_pkg::stat_t stat,
	output kvma_pkg::cmd_t  cmd
);
	import kvma_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					cmd.run_init = 1'b1;
					cmd.cnt_clr  = 1'b1;
					state_d      = ST_CLR;
				end
			end
			ST_CLR: begin
				cmd.clr_wr   = 1'b1;
				cmd.cnt_step = 1'b1;
				if (stat.s_last && stat.p_last) begin
					state_d = ST_SCAN_INIT;
				end
			end
			ST_SCAN_INIT: begin
				cmd.cnt_clr  = 1'b1;
				cmd.best_clr = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.cnt_step = 1'b1;
				if (stat.s_last && stat.p_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = stat.best_zero ? ST_OUT_INIT : ST_MREAD;
			end
			ST_MREAD: begin
				cmd.m_rd = 1'b1;
				state_d  = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_rel = 1'b1;
				state_d     = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.upd = 1'b1;
				state_d = ST_DEG_CHECK;
			end
			ST_DEG_CHECK: begin
				state_d = stat.d_ge_lim ? ST_OUT_INIT : ST_CNT_INIT;
			end
			ST_CNT_INIT: begin
				cmd.cnt_init = 1'b1;
				state_d      = ST_CNT_TERM;
			end
			ST_CNT_TERM: begin
				if (stat.c_done) begin
					state_d = ST_CNT_DONE;
				end else if (stat.a_done) begin
					cmd.cnt_next_c = 1'b1;
				end else begin
					cmd.cnt_div = 1'b1;
					state_d     = ST_CNT_WAIT;
				end
			end
			ST_CNT_WAIT: begin
				if (!stat.div_busy) begin
					cmd.cnt_acc = 1'b1;
					state_d     = ST_CNT_TERM;
				end
			end
			ST_CNT_DONE: begin
				if (stat.n_gt_idx) begin
					state_d = ST_SCAN_INIT;
				end else begin
					cmd.d_inc = 1'b1;
					state_d   = ST_DEG_CHECK;
				end
			end
			ST_OUT_INIT: begin
				cmd.cnt_clr = 1'b1;
				state_d     = ST_COL_INIT;
			end
			ST_COL_INIT: begin
				cmd.col_clr = 1'b1;
				state_d     = ST_COL_READ;
			end
			ST_COL_READ: begin
				cmd.col_rd   = 1'b1;
				cmd.col_step = 1'b1;
				if (stat.s_last) begin
					state_d = ST_COL_END;
				end
			end
			ST_COL_END: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) begin
					if (stat.p_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.pos_step = 1'b1;
						state_d      = ST_COL_INIT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

endmodule

`default_nettype wire
